@@ rtl/core/ffba_pkg.sv @@
package ffba_pkg;

  // heap geometry
  localparam int HEAP_GRANULES = 4096;
  localparam int ADDR_W        = $clog2(HEAP_GRANULES);
  localparam int SIZE_W        = ADDR_W + 1;
  localparam int HDR_W         = SIZE_W + 1;
  localparam int END_W         = ADDR_W + 1;
  localparam int WALK_W        = SIZE_W + 1;
  localparam int FREE_BIT      = SIZE_W;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [HDR_W-1:0]  hdr_t;
  typedef logic [END_W-1:0]  end_t;
  typedef logic [WALK_W-1:0] walk_t;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_APPEND,
    ST_FREE_WR,
    ST_POST
  } ffba_state_t;

  // header memory access from the controller
  typedef struct packed {
    logic  we;
    addr_t waddr;
    hdr_t  wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

endpackage

@@ rtl/core/ffba_if.sv @@
interface ffba_req_if;
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [11:0]          req_size;
  logic [11:0]          free_addr;

  modport source (output valid, output op, output req_size, output free_addr, input ready);
  modport sink   (input valid, input op, input req_size, input free_addr, output ready);
endinterface

interface ffba_rsp_if;
  logic                 valid;
  logic                 ready;
  logic [11:0]          payload_addr;
  logic                 ok;

  modport source (output valid, output payload_addr, output ok, input ready);
  modport sink   (input valid, input payload_addr, input ok, output ready);
endinterface

@@ rtl/core/ffba_hdr_ram.sv @@
module ffba_hdr_ram (
  input  logic                clk,
  input  ffba_pkg::ram_req_t  req,
  output ffba_pkg::hdr_t      rdata
);

  ffba_pkg::hdr_t mem [ffba_pkg::HEAP_GRANULES];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ rtl/core/ffba_ctrl.sv @@
module ffba_ctrl (
  input  logic                clk,
  input  logic                rst,
  ffba_req_if.sink            req,
  ffba_rsp_if.source          rsp,
  output ffba_pkg::ram_req_t  ram,
  input  ffba_pkg::hdr_t      rdata
);

  ffba_pkg::ffba_state_t state, state_next;
  ffba_pkg::addr_t       cur, cur_next;
  ffba_pkg::size_t       need, need_next;
  ffba_pkg::end_t        heap_end, heap_end_next;
  ffba_pkg::addr_t       res_addr, res_addr_next;
  logic                  res_ok, res_ok_next;
  logic                  out_valid;
  ffba_pkg::addr_t       out_addr;
  logic                  out_ok;
  logic                  out_free;

  ffba_pkg::size_t       hdr_sz;
  logic                  hdr_is_free;
  ffba_pkg::walk_t       walk_next;
  ffba_pkg::walk_t       append_end;
  ffba_pkg::addr_t       free_hdr;
  logic                  free_hit;

  assign req.ready     = (state == ffba_pkg::ST_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.payload_addr = out_addr;
  assign rsp.ok        = out_ok;
  assign out_free      = !out_valid || rsp.ready;

  // header decode and address arithmetic
  assign hdr_sz      = rdata[ffba_pkg::SIZE_W-1:0];
  assign hdr_is_free = rdata[ffba_pkg::FREE_BIT];
  assign walk_next   = ffba_pkg::walk_t'(cur) + ffba_pkg::walk_t'(hdr_sz);
  assign append_end  = ffba_pkg::walk_t'(heap_end) + ffba_pkg::walk_t'(need);
  assign free_hdr    = req.free_addr - ffba_pkg::addr_t'(1);
  assign free_hit    = (req.free_addr != '0) && (ffba_pkg::end_t'(free_hdr) < heap_end);

  // next state, memory requests and result
  always_comb begin
    state_next    = state;
    cur_next      = cur;
    need_next     = need;
    heap_end_next = heap_end;
    res_addr_next = res_addr;
    res_ok_next   = res_ok;
    ram           = '0;

    unique case (state)
      ffba_pkg::ST_IDLE: begin
        if (req.valid) begin
          if (req.op == ffba_pkg::OP_FREE) begin
            cur_next      = free_hdr;
            res_addr_next = '0;
            res_ok_next   = 1'b1;
            if (free_hit) begin
              ram.re     = 1'b1;
              ram.raddr  = free_hdr;
              state_next = ffba_pkg::ST_FREE_WR;
            end else begin
              state_next = ffba_pkg::ST_POST;
            end
          end else if (req.req_size == '0) begin
            res_addr_next = '0;
            res_ok_next   = 1'b0;
            state_next    = ffba_pkg::ST_POST;
          end else begin
            need_next = ffba_pkg::size_t'(req.req_size) + ffba_pkg::size_t'(1);
            cur_next  = '0;
            if (heap_end != '0) begin
              ram.re     = 1'b1;
              ram.raddr  = '0;
              state_next = ffba_pkg::ST_WALK;
            end else begin
              state_next = ffba_pkg::ST_APPEND;
            end
          end
        end
      end

      // one block header per cycle, header at cur is in rdata
      ffba_pkg::ST_WALK: begin
        if (hdr_sz == '0) begin
          state_next = ffba_pkg::ST_APPEND;
        end else if (hdr_is_free && (hdr_sz >= need)) begin
          ram.we        = 1'b1;
          ram.waddr     = cur;
          ram.wdata     = ffba_pkg::hdr_t'(hdr_sz);
          res_addr_next = cur + ffba_pkg::addr_t'(1);
          res_ok_next   = 1'b1;
          state_next    = ffba_pkg::ST_POST;
        end else if (walk_next < ffba_pkg::walk_t'(heap_end)) begin
          cur_next   = walk_next[ffba_pkg::ADDR_W-1:0];
          ram.re     = 1'b1;
          ram.raddr  = walk_next[ffba_pkg::ADDR_W-1:0];
        end else begin
          state_next = ffba_pkg::ST_APPEND;
        end
      end

      // bump the end pointer if the block still fits
      ffba_pkg::ST_APPEND: begin
        if (append_end > ffba_pkg::walk_t'(ffba_pkg::HEAP_GRANULES)) begin
          res_addr_next = '0;
          res_ok_next   = 1'b0;
        end else begin
          ram.we        = 1'b1;
          ram.waddr     = heap_end[ffba_pkg::ADDR_W-1:0];
          ram.wdata     = ffba_pkg::hdr_t'(need);
          res_addr_next = heap_end[ffba_pkg::ADDR_W-1:0] + ffba_pkg::addr_t'(1);
          res_ok_next   = 1'b1;
          heap_end_next = append_end[ffba_pkg::END_W-1:0];
        end
        state_next = ffba_pkg::ST_POST;
      end

      // set the free flag, keep the size bits
      ffba_pkg::ST_FREE_WR: begin
        ram.we     = 1'b1;
        ram.waddr  = cur;
        ram.wdata  = rdata | (ffba_pkg::hdr_t'(1) << ffba_pkg::FREE_BIT);
        state_next = ffba_pkg::ST_POST;
      end

      ffba_pkg::ST_POST: begin
        if (out_free) begin
          state_next = ffba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ffba_pkg::ST_IDLE;
      end
    endcase
  end

  // control and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffba_pkg::ST_IDLE;
      heap_end <= '0;
    end else begin
      state    <= state_next;
      heap_end <= heap_end_next;
    end
    cur      <= cur_next;
    need     <= need_next;
    res_addr <= res_addr_next;
    res_ok   <= res_ok_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ffba_pkg::ST_POST) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if ((state == ffba_pkg::ST_POST) && out_free) begin
      out_addr <= res_addr;
      out_ok   <= res_ok;
    end
  end

endmodule

@@ rtl/core/first_fit_block_allocator_unit.sv @@
// first-fit allocator over a heap of 4096 granules, one header granule per block
// req channel: op (allocate or free), req_size for allocate, free_addr for free
// rsp channel: one response per request, payload_addr and ok
// allocate takes req_size + 1 granules: the first free block large enough is
// reused whole, otherwise a new block is added at the end of the heap if it fits
// free sets the free flag of the header just before free_addr
// a request is taken only while the controller is idle, one at a time
// a free or a zero-size allocate goes to ST_POST, a free that hits a heap
// block through ST_FREE_WR first; an allocate walks the block headers from
// granule 0 and may go through ST_APPEND; the header memory read is registered
// the controller is idle again, ready for the next request, once the
// response loads into the output register
// a finished response waits in the output register while rsp is stalled;
// the next request is accepted meanwhile and its response holds in the
// controller until the output register frees
// reset clears the end pointer and the handshake state; header memory is
// not cleared and needs no clearing pass
module first_fit_block_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  ffba_req_if.sink    req,
  ffba_rsp_if.source  rsp
);

  ffba_pkg::ram_req_t ram;
  ffba_pkg::hdr_t     rdata;

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .ram   (ram),
    .rdata (rdata)
  );

  ffba_hdr_ram u_ram (
    .clk   (clk),
    .req   (ram),
    .rdata (rdata)
  );

endmodule

@@ tb/tb_first_fit_block_allocator_unit.sv @@
module tb_first_fit_block_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1900;
  localparam int PHASE_LEN       = RANDOM_REQUESTS / 4;
  localparam int DRAIN_CYCLES    = 20;

  typedef struct packed {
    ffba_pkg::addr_t payload_addr;
    logic            ok;
  } grant_t;

  // heap state mirror and queue of grants still owed by the block
  class heap_scoreboard;
    ffba_pkg::hdr_t headers [ffba_pkg::HEAP_GRANULES];
    int unsigned    heap_top;
    int unsigned    block_starts [$];
    grant_t         due_grants [$];
    int unsigned    mismatches;

    function new();
      foreach (headers[i]) headers[i] = '0;
      heap_top   = 0;
      mismatches = 0;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // first-fit walk from granule 0, else append at the heap top
    function grant_t allocate_grant(ffba_pkg::addr_t size);
      grant_t      g;
      int unsigned need;
      int unsigned pos;
      int unsigned sz;
      g = '0;
      if (size == 0) return g;
      need = int'(size) + 1;
      pos  = 0;
      while (pos < heap_top) begin
        sz = 32'(headers[pos][ffba_pkg::SIZE_W-1:0]);
        if (sz == 0) break;
        if (headers[pos][ffba_pkg::FREE_BIT] && sz >= need) begin
          headers[pos]   = ffba_pkg::hdr_t'(sz);
          g.payload_addr = ffba_pkg::addr_t'(pos + 1);
          g.ok           = 1'b1;
          return g;
        end
        pos += sz;
      end
      if (heap_top + need > ffba_pkg::HEAP_GRANULES) return g;
      headers[heap_top] = ffba_pkg::hdr_t'(need);
      block_starts.push_back(heap_top);
      g.payload_addr = ffba_pkg::addr_t'(heap_top + 1);
      g.ok           = 1'b1;
      heap_top += need;
      return g;
    endfunction

    // accepted request: update the mirror and queue its grant
    function void take_request(logic op, ffba_pkg::addr_t size, ffba_pkg::addr_t faddr);
      grant_t g;
      if (op == ffba_pkg::OP_ALLOC) begin
        g = allocate_grant(size);
      end else begin
        if (faddr != 0 && int'(faddr) - 1 < int'(heap_top))
          headers[faddr - 1][ffba_pkg::FREE_BIT] = 1'b1;
        g = '{payload_addr: '0, ok: 1'b1};
      end
      due_grants.push_back(g);
    endfunction

    task check_grant(ffba_pkg::addr_t addr, logic ok);
      grant_t want;
      if (due_grants.size() == 0) begin
        report_mismatch($sformatf("grant with no request pending: addr %0d ok %0b", addr, ok));
        return;
      end
      want = due_grants.pop_front();
      if (addr !== want.payload_addr)
        report_mismatch($sformatf("payload_addr %0d, want %0d", addr, want.payload_addr));
      if (ok !== want.ok)
        report_mismatch($sformatf("ok %0b, want %0b", ok, want.ok));
    endtask
  endclass

  logic clk;
  logic rst;
  int unsigned req_idle_pct;
  int unsigned rsp_stall_pct;
  heap_scoreboard sb = new();

  ffba_req_if req();
  ffba_rsp_if rsp();

  first_fit_block_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #1_000_000_000;
    $display("Mismatches found");
    $finish;
  end

  // random backpressure on the grant side
  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // check every accepted grant
  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1)
      sb.check_grant(rsp.payload_addr, rsp.ok);
  end

  // present one request and hold it until accepted
  task automatic issue(logic op, ffba_pkg::addr_t size, ffba_pkg::addr_t faddr);
    req.valid     <= 1'b1;
    req.op        <= op;
    req.req_size  <= size;
    req.free_addr <= faddr;
    do @(posedge clk); while (req.ready !== 1'b1);
    sb.take_request(op, size, faddr);
  endtask

  initial begin
    int unsigned     roll;
    int unsigned     idx;
    int unsigned     start;
    ffba_pkg::addr_t size;
    ffba_pkg::addr_t faddr;

    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.op        <= ffba_pkg::OP_ALLOC;
    req.req_size  <= '0;
    req.free_addr <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero size, frees outside the heap, overflow, reuse, double free
    issue(ffba_pkg::OP_ALLOC, 12'd0,    12'd0);
    issue(ffba_pkg::OP_FREE,  12'd5,    12'd1);
    issue(ffba_pkg::OP_FREE,  12'd0,    12'd4095);
    issue(ffba_pkg::OP_ALLOC, 12'd1,    12'd0);
    issue(ffba_pkg::OP_ALLOC, 12'd4095, 12'd4095);
    issue(ffba_pkg::OP_ALLOC, 12'd2,    12'd0);
    issue(ffba_pkg::OP_ALLOC, 12'd8,    12'd0);
    issue(ffba_pkg::OP_FREE,  12'd4095, 12'd3);
    issue(ffba_pkg::OP_ALLOC, 12'd3,    12'd0);
    issue(ffba_pkg::OP_ALLOC, 12'd2,    12'd0);
    issue(ffba_pkg::OP_FREE,  12'd0,    12'd1);
    issue(ffba_pkg::OP_FREE,  12'd0,    12'd6);
    issue(ffba_pkg::OP_ALLOC, 12'd1,    12'd0);
    issue(ffba_pkg::OP_ALLOC, 12'd1,    12'd0);
    issue(ffba_pkg::OP_FREE,  12'd0,    12'd6);
    issue(ffba_pkg::OP_FREE,  12'd0,    12'd6);
    issue(ffba_pkg::OP_FREE,  12'd0,    12'd2048);
    issue(ffba_pkg::OP_ALLOC, 12'd4094, 12'd4095);
    issue(ffba_pkg::OP_ALLOC, 12'd3,    12'd0);
    issue(ffba_pkg::OP_FREE,  12'd0,    12'd19);
    issue(ffba_pkg::OP_FREE,  12'd0,    12'd15);
    issue(ffba_pkg::OP_ALLOC, 12'd3,    12'd0);

    // random requests over four idling phases
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      case (n / PHASE_LEN)
        0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
        1:       begin req_idle_pct = 51; rsp_stall_pct = 0;  end
        2:       begin req_idle_pct = 0;  rsp_stall_pct = 51; end
        default: begin req_idle_pct = 8;  rsp_stall_pct = 8;  end
      endcase

      // sender idle gap
      if ($urandom_range(99) < req_idle_pct) begin
        req.valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < req_idle_pct);
      end

      roll = $urandom_range(99);
      if (roll < 55) begin
        // allocate, mostly small, sometimes filling the heap to the last granule
        roll = $urandom_range(99);
        if (sb.heap_top >= 3800 && sb.heap_top < ffba_pkg::HEAP_GRANULES &&
            $urandom_range(99) < 15)
          size = ffba_pkg::addr_t'(ffba_pkg::HEAP_GRANULES - 1 - sb.heap_top);
        else if (roll < 2)
          size = '0;
        else if (roll < 60)
          size = ffba_pkg::addr_t'($urandom_range(8, 1));
        else if (roll < 90)
          size = ffba_pkg::addr_t'($urandom_range(64, 9));
        else if (roll < 98)
          size = ffba_pkg::addr_t'($urandom_range(400, 65));
        else
          size = ffba_pkg::addr_t'($urandom_range(ffba_pkg::HEAP_GRANULES - 1, 401));
        issue(ffba_pkg::OP_ALLOC, size,
              ffba_pkg::addr_t'($urandom_range(ffba_pkg::HEAP_GRANULES - 1)));
      end else begin
        // free: a block in use, any block, or an address past the heap top
        roll = $urandom_range(99);
        if (sb.block_starts.size() == 0 ||
            (roll < 12 && sb.heap_top < ffba_pkg::HEAP_GRANULES - 1)) begin
          faddr = ffba_pkg::addr_t'($urandom_range(ffba_pkg::HEAP_GRANULES - 1,
                                                   sb.heap_top + 1));
        end else begin
          idx   = $urandom_range(sb.block_starts.size() - 1);
          start = sb.block_starts[idx];
          if (roll < 85) begin
            for (int t = 0; t < 8 && sb.headers[start][ffba_pkg::FREE_BIT]; t++) begin
              idx   = $urandom_range(sb.block_starts.size() - 1);
              start = sb.block_starts[idx];
            end
          end
          faddr = ffba_pkg::addr_t'(start + 1);
        end
        issue(ffba_pkg::OP_FREE, ffba_pkg::addr_t'($urandom), faddr);
      end
    end

    // drain outstanding grants
    req.valid     <= 1'b0;
    rsp_stall_pct = 0;
    while (sb.due_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ first_fit_block_allocator_unit.f @@
rtl/core/ffba_pkg.sv
rtl/core/ffba_if.sv
rtl/core/ffba_hdr_ram.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator_unit.sv
tb/tb_first_fit_block_allocator_unit.sv
